// ===== rtl/core/wct_pkg.sv =====
// Shared types and fixed field widths of the window centroid tracker.
package wct_pkg;

  localparam int TelW   = 3;
  localparam int CoordW = 11;
  localparam int ColorW = 24;
  localparam int PredW  = 12;
  localparam int ExtW   = 13;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV_X = 4'b0010,
    ST_DIV_Y = 4'b0100,
    ST_OUT   = 4'b1000
  } wct_state_e;

endpackage

// ===== rtl/core/window_centroid_tracker.sv =====
// Window centroid tracker: target pixel accumulation and per-window centroid prediction.
//
// The slave stream carries the interior pixels of one square observation window,
// column by column. Each transfer holds the window centre and the pixel colour in
// tdata, the telescope number in tuser, and tlast marks the final interior pixel.
// Pixels that differ from the background colour register are counted and their
// offsets summed. Ordinary pixels are taken at one per cycle while the block is idle.
// The last pixel starts the prediction: two restoring divisions, x then y, run
// one quotient bit per cycle on a single shared subtractor while tready is low,
// and the result then passes through the output state to the output register;
// without a division the block goes from the last pixel straight to that state.
// The master stream carries one prediction per window in an output register.
// While the receiver stalls, further pixels are still taken, but a finished
// prediction waits in the sequencer, with tready low, until the register is free.
// Reset clears the accumulators, the per-telescope seen flags, the background colour
// and the output valid; stored predictions hold no value until written. The user must
// write the background colour via cfg_we_i only while idle; the block never checks.
module window_centroid_tracker #(
  parameter int WINDOW_SIZE = 64,
  parameter int TELESCOPES  = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,   // background_color
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // window_x, window_y, pixel_color, zero fill
  input  logic [2:0]  s_axis_tuser,  // telescope_index
  input  logic        s_axis_tlast,  // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // predicted_x, predicted_y
  output logic [3:0]  m_axis_tuser   // telescope_out, target_found
);

  localparam int Interior = WINDOW_SIZE - 2;
  localparam int MaxHits  = Interior * Interior;
  localparam int Half     = WINDOW_SIZE / 2;
  localparam int PosW     = $clog2(WINDOW_SIZE - 1);
  localparam int CntW     = $clog2(MaxHits + 1);
  localparam int SumW     = $clog2(MaxHits * Interior + 1);
  localparam int StepW    = $clog2(SumW);

  localparam logic [PosW-1:0]  PosLast  = PosW'(Interior);
  localparam logic [PosW-1:0]  PosFirst = PosW'(1);
  localparam logic [CntW-1:0]  CntMax   = CntW'(MaxHits);
  localparam logic [StepW-1:0] StepLast = StepW'(SumW - 1);
  localparam logic [wct_pkg::ExtW-1:0] HalfExt = wct_pkg::ExtW'(Half);
  localparam logic [wct_pkg::ExtW-1:0] TopExt  = wct_pkg::ExtW'(2047 + Half);

  wct_pkg::wct_state_e state_q, state_d;

  logic [wct_pkg::ColorW-1:0] bg_q;
  logic [SumW-1:0]            sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CntW-1:0]            hit_count_q, hit_count_d;
  logic [PosW-1:0]            col_q, col_d, row_q, row_d;
  logic                       seen_q [TELESCOPES];
  logic [wct_pkg::PredW-1:0]  pred_x_q [TELESCOPES];
  logic [wct_pkg::PredW-1:0]  pred_y_q [TELESCOPES];

  logic [wct_pkg::TelW-1:0]   tel_q;
  logic [wct_pkg::CoordW-1:0] wx_q, wy_q;
  logic                       found_q, use_prev_q;
  logic [SumW-1:0]            dq_q, dq_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic [StepW-1:0]           step_q;
  logic [PosW-1:0]            qx_q;

  logic                       m_valid_q;
  logic [23:0]                m_data_q;
  logic [3:0]                 m_user_q;

  logic [wct_pkg::TelW-1:0]   in_tel;
  logic [wct_pkg::CoordW-1:0] in_wx, in_wy;
  logic [wct_pkg::ColorW-1:0] in_pix;
  logic                       in_fire, hit_now, tel_ok, seen_rd, found_now, divide_now;
  logic                       out_free, out_load, tel_q_ok;
  logic [CntW:0]              rem_sh, rem_diff;
  logic                       rem_ge;
  logic [wct_pkg::PredW-1:0]  prev_x, prev_y, res_x, res_y;
  logic [wct_pkg::ExtW-1:0]   ext_x, ext_y, off_x, off_y;

  assign in_wx   = s_axis_tdata[10:0];
  assign in_wy   = s_axis_tdata[21:11];
  assign in_pix  = s_axis_tdata[45:22];
  assign in_tel  = s_axis_tuser;

  assign s_axis_tready = (state_q == wct_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign hit_now       = (in_pix != bg_q);
  assign tel_ok        = int'(in_tel) < TELESCOPES;
  assign tel_q_ok      = int'(tel_q) < TELESCOPES;

  always_comb begin
    seen_rd = 1'b0;
    prev_x  = '0;
    prev_y  = '0;
    for (int k = 0; k < TELESCOPES; k++) begin
      if (int'(in_tel) == k) begin
        seen_rd = seen_q[k];
      end
      if (int'(tel_q) == k) begin
        prev_x = pred_x_q[k];
        prev_y = pred_y_q[k];
      end
    end
  end

  always_comb begin
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    hit_count_d = hit_count_q;
    if (hit_now && (hit_count_q < CntMax)) begin
      sum_x_d     = sum_x_q + SumW'(col_q);
      sum_y_d     = sum_y_q + SumW'(row_q);
      hit_count_d = hit_count_q + CntW'(1);
    end
    if (row_q >= PosLast) begin
      row_d = PosFirst;
      col_d = (col_q >= PosLast) ? PosFirst : col_q + PosW'(1);
    end else begin
      row_d = row_q + PosW'(1);
      col_d = col_q;
    end
  end

  assign found_now  = tel_ok && (seen_rd || hit_now);
  assign divide_now = found_now && (hit_count_d != '0);

  assign rem_sh   = {rem_q, dq_q[SumW-1]};
  assign rem_diff = rem_sh - {1'b0, hit_count_q};
  assign rem_ge   = (rem_sh >= {1'b0, hit_count_q});
  assign rem_d    = rem_ge ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
  assign dq_d     = {dq_q[SumW-2:0], rem_ge};

  assign ext_x = {2'b00, wx_q} + wct_pkg::ExtW'(qx_q);
  assign ext_y = {2'b00, wy_q} + wct_pkg::ExtW'(dq_q[PosW-1:0]);
  assign off_x = ext_x - HalfExt;
  assign off_y = ext_y - HalfExt;

  always_comb begin
    if (!found_q) begin
      res_x = {1'b0, wx_q};
      res_y = {1'b0, wy_q};
    end else if (use_prev_q) begin
      res_x = prev_x;
      res_y = prev_y;
    end else begin
      res_x = (ext_x > TopExt) ? wct_pkg::PredW'(2047) : off_x[wct_pkg::PredW-1:0];
      res_y = (ext_y > TopExt) ? wct_pkg::PredW'(2047) : off_y[wct_pkg::PredW-1:0];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == wct_pkg::ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wct_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = divide_now ? wct_pkg::ST_DIV_X : wct_pkg::ST_OUT;
        end
      end
      wct_pkg::ST_DIV_X: begin
        if (step_q == StepLast) begin
          state_d = wct_pkg::ST_DIV_Y;
        end
      end
      wct_pkg::ST_DIV_Y: begin
        if (step_q == StepLast) begin
          state_d = wct_pkg::ST_OUT;
        end
      end
      wct_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = wct_pkg::ST_IDLE;
        end
      end
      default: state_d = wct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wct_pkg::ST_IDLE;
      bg_q        <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      hit_count_q <= '0;
      col_q       <= PosFirst;
      row_q       <= PosFirst;
      m_valid_q   <= 1'b0;
      step_q      <= '0;
      for (int k = 0; k < TELESCOPES; k++) begin
        seen_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        sum_x_q     <= sum_x_d;
        sum_y_q     <= sum_y_d;
        hit_count_q <= hit_count_d;
        col_q       <= col_d;
        row_q       <= row_d;
        for (int k = 0; k < TELESCOPES; k++) begin
          if (hit_now && int'(in_tel) == k) begin
            seen_q[k] <= 1'b1;
          end
        end
      end else if (out_load) begin
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        hit_count_q <= '0;
        col_q       <= PosFirst;
        row_q       <= PosFirst;
      end
      if (state_q == wct_pkg::ST_DIV_X || state_q == wct_pkg::ST_DIV_Y) begin
        step_q <= (step_q == StepLast) ? '0 : step_q + StepW'(1);
      end else begin
        step_q <= '0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      tel_q      <= in_tel;
      wx_q       <= in_wx;
      wy_q       <= in_wy;
      found_q    <= found_now;
      use_prev_q <= found_now && !divide_now;
      dq_q       <= sum_x_d;
      rem_q      <= '0;
    end else if (state_q == wct_pkg::ST_DIV_X) begin
      if (step_q == StepLast) begin
        qx_q  <= dq_d[PosW-1:0];
        dq_q  <= sum_y_q;
        rem_q <= '0;
      end else begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
      end
    end else if (state_q == wct_pkg::ST_DIV_Y) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if (out_load) begin
      m_data_q <= {res_y, res_x};
      m_user_q <= {found_q, tel_q};
      for (int k = 0; k < TELESCOPES; k++) begin
        if (tel_q_ok && int'(tel_q) == k) begin
          pred_x_q[k] <= res_x;
          pred_y_q[k] <= res_y;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wct_pkg::ST_DIV_X || state_q == wct_pkg::ST_DIV_Y) |-> hit_count_q != '0)
    else $error("Division started with a zero hit count.");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wct_pkg::ST_DIV_X || state_q == wct_pkg::ST_DIV_Y) |-> rem_q < hit_count_q)
    else $error("Division remainder is not below the divisor.");

  a_hit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_count_q <= CntMax)
    else $error("Hit count exceeds the window interior.");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == wct_pkg::ST_OUT))
    else $error("Result presented without a completed prediction.");
`endif

endmodule

// ===== tb/sv/window_centroid_tracker_tb.sv =====
// Self-checking testbench for the window centroid tracker with a built-in centroid predictor.
module window_centroid_tracker_tb;

  localparam int WINDOW_SIZE   = 64;
  localparam int TELESCOPES    = 6;
  localparam int INTERIOR_LAST = WINDOW_SIZE - 2;
  localparam int MAX_HITS      = INTERIOR_LAST * INTERIOR_LAST;
  localparam int HALF_WINDOW   = WINDOW_SIZE / 2;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_LIMIT    = 3000;

  typedef struct {
    logic [wct_pkg::TelW-1:0]   tel;
    logic [wct_pkg::CoordW-1:0] wx;
    logic [wct_pkg::CoordW-1:0] wy;
    logic [wct_pkg::ColorW-1:0] color;
    logic                       last;
    logic                       drain;
  } pixel_t;

  typedef struct {
    logic [wct_pkg::TelW-1:0]         tel;
    logic                             found;
    logic signed [wct_pkg::PredW-1:0] px;
    logic signed [wct_pkg::PredW-1:0] py;
  } centroid_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [23:0]       cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata = '0;   // window_x, window_y, pixel_color, zero fill
  logic [2:0]        s_axis_tuser = '0;   // telescope_index
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // predicted_x, predicted_y
  logic [3:0]        m_axis_tuser;        // telescope_out, target_found

  pixel_t    pixel_q[$];
  centroid_t centroid_q[$];
  pixel_t    cur_pixel;

  logic [wct_pkg::ColorW-1:0]       bg_color = '0;
  bit                               seen_flag[TELESCOPES];
  logic signed [wct_pkg::PredW-1:0] stored_px[TELESCOPES];
  logic signed [wct_pkg::PredW-1:0] stored_py[TELESCOPES];
  logic [17:0]                      sum_x = '0;
  logic [17:0]                      sum_y = '0;
  logic [11:0]                      hit_count = '0;
  logic [5:0]                       column_pos = 6'd1;
  logic [5:0]                       row_pos = 6'd1;

  bit plan_seen[TELESCOPES];
  int plan_hits = 0;

  int mismatches = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int run_left = 0;
  int stall_left = 0;

  window_centroid_tracker #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .TELESCOPES (TELESCOPES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic int clamp_pred(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // Mirrors the block for one accepted pixel and queues the prediction at the window end.
  task automatic accumulate_pixel(input pixel_t p);
    bit        valid_tel;
    int        vx;
    int        vy;
    centroid_t c;
    valid_tel = p.tel < TELESCOPES;
    if (p.color != bg_color) begin
      if (hit_count < MAX_HITS) begin
        sum_x = sum_x + column_pos;
        sum_y = sum_y + row_pos;
        hit_count = hit_count + 1'b1;
      end
      if (valid_tel) seen_flag[p.tel] = 1'b1;
    end
    if (row_pos >= INTERIOR_LAST) begin
      row_pos = 6'd1;
      column_pos = (column_pos >= INTERIOR_LAST) ? 6'd1 : column_pos + 6'd1;
    end else begin
      row_pos = row_pos + 6'd1;
    end
    if (p.last) begin
      c.tel = p.tel;
      c.found = valid_tel ? seen_flag[p.tel] : 1'b0;
      if (c.found) begin
        if (hit_count != 0) begin
          vx = clamp_pred(int'(p.wx) - HALF_WINDOW + int'(sum_x) / int'(hit_count));
          vy = clamp_pred(int'(p.wy) - HALF_WINDOW + int'(sum_y) / int'(hit_count));
        end else begin
          vx = stored_px[p.tel];
          vy = stored_py[p.tel];
        end
      end else begin
        vx = p.wx;
        vy = p.wy;
      end
      c.px = wct_pkg::PredW'(vx);
      c.py = wct_pkg::PredW'(vy);
      if (valid_tel) begin
        stored_px[p.tel] = c.px;
        stored_py[p.tel] = c.py;
      end
      centroid_q.push_back(c);
      sum_x = '0;
      sum_y = '0;
      hit_count = '0;
      column_pos = 6'd1;
      row_pos = 6'd1;
    end
  endtask

  function automatic logic [wct_pkg::ColorW-1:0] target_color();
    logic [wct_pkg::ColorW-1:0] c;
    c = wct_pkg::ColorW'($urandom());
    if (c == bg_color) c = c ^ 24'h000001;
    return c;
  endfunction

  // Queues one pixel. A window that would close on a seen telescope without any
  // target pixel gets its last pixel turned into a target, as a stored prediction
  // to repeat may not exist in that situation.
  task automatic plan_pixel(input logic [wct_pkg::TelW-1:0] tel,
                            input logic [wct_pkg::CoordW-1:0] wx,
                            input logic [wct_pkg::CoordW-1:0] wy,
                            input logic [wct_pkg::ColorW-1:0] color,
                            input logic last, input logic drain);
    pixel_t p;
    p.tel = tel;
    p.wx = wx;
    p.wy = wy;
    p.color = color;
    p.last = last;
    p.drain = drain;
    if (last && tel < TELESCOPES && plan_seen[tel] && plan_hits == 0 &&
        color == bg_color) begin
      p.color = target_color();
    end
    if (p.color != bg_color) begin
      plan_hits++;
      if (tel < TELESCOPES) plan_seen[tel] = 1'b1;
    end
    if (last) plan_hits = 0;
    pixel_q.push_back(p);
  endtask

  task automatic plan_window(input logic [wct_pkg::TelW-1:0] tel,
                             input logic [wct_pkg::CoordW-1:0] wx,
                             input logic [wct_pkg::CoordW-1:0] wy, input int len,
                             input int hit_pct, input bit drain);
    logic [wct_pkg::TelW-1:0]   ptel;
    logic [wct_pkg::ColorW-1:0] color;
    for (int i = 0; i < len; i++) begin
      ptel = ($urandom_range(0, 7) == 0) ? wct_pkg::TelW'($urandom_range(0, 7)) : tel;
      color = ($urandom_range(0, 99) < hit_pct) ? target_color() : bg_color;
      plan_pixel(ptel, wx, wy, color, i == len - 1, drain && i == 0);
    end
  endtask

  task automatic plan_random(input int items);
    int count;
    int len;
    int pct;
    count = 0;
    while (count < items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 140) : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 30;
        2: pct = 70;
        default: pct = 100;
      endcase
      plan_window(wct_pkg::TelW'($urandom_range(0, 7)),
                  wct_pkg::CoordW'($urandom_range(0, 2047)),
                  wct_pkg::CoordW'($urandom_range(0, 2047)),
                  len, pct, $urandom_range(0, 9) == 0);
      count += len;
    end
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_axis_tvalid || centroid_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_background(input logic [wct_pkg::ColorW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bg_color = value;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) accumulate_pixel(cur_pixel);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0 &&
                     !(pixel_q[0].drain && centroid_q.size() != 0)) begin
          cur_pixel = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur_pixel.color, cur_pixel.wy, cur_pixel.wx};
          s_axis_tuser <= cur_pixel.tel;
          s_axis_tlast <= cur_pixel.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    centroid_t exp_c;
    logic [wct_pkg::TelW-1:0]         got_tel;
    logic                             got_found;
    logic signed [wct_pkg::PredW-1:0] got_px;
    logic signed [wct_pkg::PredW-1:0] got_py;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_tel = m_axis_tuser[2:0];
        got_found = m_axis_tuser[3];
        got_px = $signed(m_axis_tdata[11:0]);
        got_py = $signed(m_axis_tdata[23:12]);
        if (centroid_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected prediction: tel %0d found %0b x %0d y %0d",
                     got_tel, got_found, got_px, got_py);
          end
        end else begin
          exp_c = centroid_q.pop_front();
          if (got_tel !== exp_c.tel || got_found !== exp_c.found ||
              got_px !== exp_c.px || got_py !== exp_c.py) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Prediction mismatch: expected tel %0d found %0b x %0d y %0d,",
                       exp_c.tel, exp_c.found, exp_c.px, exp_c.py,
                       " got tel %0d found %0b x %0d y %0d",
                       got_tel, got_found, got_px, got_py);
            end
          end
        end
      end
      if (run_left > 0) begin
        run_left--;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
                                                 $urandom_range(1, 30);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Short windows on the reset background colour, covering the corner cases.
    plan_pixel(3'd0, 11'd0, 11'd0, 24'h000000, 1'b1, 1'b1);
    plan_pixel(3'd5, 11'd2047, 11'd2047, 24'hFFFFFF, 1'b1, 1'b0);
    plan_pixel(3'd1, 11'd0, 11'd0, 24'h000000, 1'b0, 1'b0);
    plan_pixel(3'd1, 11'd0, 11'd0, 24'h000001, 1'b1, 1'b0);
    plan_pixel(3'd6, 11'd1234, 11'd567, 24'h800000, 1'b1, 1'b0);
    plan_pixel(3'd7, 11'd2047, 11'd0, 24'h000000, 1'b1, 1'b0);
    plan_pixel(3'd0, 11'd1, 11'd2, 24'h5A5A5A, 1'b0, 1'b0);
    plan_pixel(3'd3, 11'd100, 11'd200, 24'h000000, 1'b1, 1'b0);
    plan_pixel(3'd0, 11'd1024, 11'd31, 24'hA5A5A5, 1'b0, 1'b1);
    plan_pixel(3'd0, 11'd1024, 11'd31, 24'h000000, 1'b0, 1'b0);
    plan_pixel(3'd0, 11'd1024, 11'd31, 24'h123456, 1'b1, 1'b0);
    plan_pixel(3'd5, 11'd32, 11'd1023, 24'h000000, 1'b0, 1'b1);
    plan_pixel(3'd5, 11'd32, 11'd1023, 24'h000000, 1'b1, 1'b0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // A full first column with a late cluster that drives the prediction past
    // the lower screen edge.
    write_background(24'hFFFFFF);
    for (int i = 0; i < INTERIOR_LAST; i++) begin
      plan_pixel(3'd3, 11'd2047, 11'd2047, (i >= 40) ? target_color() : bg_color,
                 i == INTERIOR_LAST - 1, 1'b0);
    end
    wait_idle();

    write_background(wct_pkg::ColorW'($urandom_range(0, 24'hFFFFFF)));
    plan_random(250);
    wait_idle();

    write_background(24'h000000);
    plan_random(250);
    wait_idle();

    write_background(wct_pkg::ColorW'($urandom_range(0, 24'hFFFFFF)));
    plan_random(220);
    wait_idle();

    if (mismatches == 0 && centroid_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
